@@ rtl/core/slm_pkg.sv @@
// shared types and codes for the sorted list merge block
`default_nettype none

package slm_pkg;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic [5:0]         position;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_MERGE  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] ST_ELEM  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/sorted_list_merge.sv @@
// top level: two list stores merged in ascending order on command
//
//  channel | valid      | ready      | payload
//  --------+------------+------------+----------------------
//  in      | i_in_valid | o_in_ready | i_in_item  (t_in_item)
//  out     | o_out_valid| i_out_ready| o_out_item (t_out_item)
//
// a merge emits one element per cycle while the output is not stalled
// the pace of the merge is set by the output handshake, not the registered store read
// reset clears counts, indices, state and the output valid flag; output data and stores need no clearing
// a stalled output holds the merge in place; input waits while merging
`default_nettype none

module sorted_list_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire slm_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output slm_pkg::t_out_item      o_out_item
);

    import slm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic [5:0]    r_pos, n_pos;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;

    logic          we_a, we_b;
    logic [31:0]   rd_a, rd_b;
    logic          in_acc, can_push, take_a, a_left, b_left;

    slm_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_in_item.value),
        .i_raddr (n_ia[AW-1:0]),
        .o_rdata (rd_a)
    );

    slm_list_mem #(.DEPTH(LIST_DEPTH), .AW(AW)) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_in_item.value),
        .i_raddr (n_ib[AW-1:0]),
        .o_rdata (rd_b)
    );

    assign can_push    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE) && can_push;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign a_left = r_ia < r_cnt_a;
    assign b_left = r_ib < r_cnt_b;
    assign take_a = a_left && (!b_left || ($signed(rd_a) <= $signed(rd_b)));

    always_comb begin
        n_state     = r_state;
        n_cnt_a     = r_cnt_a;
        n_cnt_b     = r_cnt_b;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        we_a        = 1'b0;
        we_b        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.mode)
                        MODE_LOAD_A: begin
                            if (r_cnt_a == FULL_CNT) begin
                                n_out       = '{value_res: '0, position: '0,
                                                status: ST_FULL, last: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                we_a    = 1'b1;
                                n_cnt_a = r_cnt_a + 1'b1;
                            end
                        end
                        MODE_LOAD_B: begin
                            if (r_cnt_b == FULL_CNT) begin
                                n_out       = '{value_res: '0, position: '0,
                                                status: ST_FULL, last: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                we_b    = 1'b1;
                                n_cnt_b = r_cnt_b + 1'b1;
                            end
                        end
                        MODE_MERGE: begin
                            if (r_cnt_a == '0 && r_cnt_b == '0) begin
                                n_out       = '{value_res: '0, position: '0,
                                                status: ST_EMPTY, last: 1'b1};
                                n_out_valid = 1'b1;
                            end else begin
                                n_ia    = '0;
                                n_ib    = '0;
                                n_pos   = '0;
                                n_state = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (can_push) begin
                    if (take_a) begin
                        n_ia            = r_ia + 1'b1;
                        n_out.value_res = rd_a;
                    end else begin
                        n_ib            = r_ib + 1'b1;
                        n_out.value_res = rd_b;
                    end
                    n_out.position = r_pos;
                    n_out.status   = ST_ELEM;
                    n_out.last     = (n_ia == r_cnt_a) && (n_ib == r_cnt_b);
                    n_out_valid    = 1'b1;
                    n_pos          = r_pos + 1'b1;
                    if (n_out.last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

@@ rtl/core/slm_list_mem.sv @@
// one list store: single write port, registered read port
`default_nettype none

module slm_list_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);

    logic [31:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// testbench for sorted_list_merge: loads and merges checked against a behavioral list model
`default_nettype none

module tb_top;
    import slm_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_TARGET = 250;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    logic signed [31:0] shadow_a [LIST_DEPTH];
    logic signed [31:0] shadow_b [LIST_DEPTH];
    int unsigned        fill_a = 0;
    int unsigned        fill_b = 0;
    t_out_item          pending[$];

    int  mismatches = 0;
    int  sent_items = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;

    sorted_list_merge #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic t_out_item make_result(logic signed [31:0] v, int unsigned pos,
                                              logic [1:0] st, logic lst);
        t_out_item r;
        r.value_res = v;
        r.position  = pos[5:0];
        r.status    = st;
        r.last      = lst;
        return r;
    endfunction

    // expected results of one accepted transaction
    task automatic predict_list_op(input t_in_item it);
        int unsigned ia;
        int unsigned ib;
        int unsigned total;
        int unsigned n;
        logic signed [31:0] v;
        ia = 0;
        ib = 0;
        n = 0;
        total = fill_a + fill_b;
        case (it.mode)
            MODE_LOAD_A: begin
                if (fill_a >= LIST_DEPTH) begin
                    pending.push_back(make_result(0, 0, ST_FULL, 1'b1));
                end else begin
                    shadow_a[fill_a] = it.value;
                    fill_a++;
                end
            end
            MODE_LOAD_B: begin
                if (fill_b >= LIST_DEPTH) begin
                    pending.push_back(make_result(0, 0, ST_FULL, 1'b1));
                end else begin
                    shadow_b[fill_b] = it.value;
                    fill_b++;
                end
            end
            MODE_MERGE: begin
                if (total == 0) begin
                    pending.push_back(make_result(0, 0, ST_EMPTY, 1'b1));
                end else begin
                    while (ia < fill_a || ib < fill_b) begin
                        if (ia < fill_a && (ib >= fill_b || shadow_a[ia] <= shadow_b[ib])) begin
                            v = shadow_a[ia];
                            ia++;
                        end else begin
                            v = shadow_b[ib];
                            ib++;
                        end
                        pending.push_back(make_result(v, n, ST_ELEM, n + 1 == total));
                        n++;
                    end
                    fill_a = 0;
                    fill_b = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [1:0] mode, input logic signed [31:0] value);
        t_in_item it;
        it.mode  = mode;
        it.value = value;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        predict_list_op(it);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] rand_value(int span);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7fff_ffff;
        if (span == 0) return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // one load sequence into both lists, then a merge
    task automatic merge_round(input int na, input int nb, input int span, input bit ordered);
        int qa[$];
        int qb[$];
        qa = {};
        qb = {};
        repeat (na) qa.push_back(rand_value(span));
        repeat (nb) qb.push_back(rand_value(span));
        if (ordered) begin
            qa.sort();
            qb.sort();
        end
        while (qa.size() > 0 || qb.size() > 0) begin
            if (!quiet && $urandom_range(0, 24) == 0)
                send_item(MODE_UNUSED, $urandom);
            if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1) == 0))
                send_item(MODE_LOAD_A, qa.pop_front());
            else
                send_item(MODE_LOAD_B, qb.pop_front());
        end
        send_item(MODE_MERGE, $urandom);
    endtask

    function automatic int rand_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(28, 34);
        return $urandom_range(0, 6);
    endfunction

    task automatic drain_pending();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
    endtask

    task automatic test_empty_merge();
        send_item(MODE_MERGE, 32'h7fff_ffff);
        send_item(MODE_UNUSED, 32'hffff_ffff);
        send_item(MODE_MERGE, 32'h0);
    endtask

    task automatic test_extremes();
        send_item(MODE_LOAD_A, 32'h8000_0000);
        send_item(MODE_LOAD_A, -32'sd1);
        send_item(MODE_LOAD_A, 32'sd0);
        send_item(MODE_LOAD_A, 32'h7fff_ffff);
        send_item(MODE_LOAD_B, 32'h8000_0000);
        send_item(MODE_LOAD_B, 32'sd0);
        send_item(MODE_LOAD_B, 32'sd1);
        send_item(MODE_LOAD_B, 32'h7fff_ffff);
        send_item(MODE_MERGE, 32'h5a5a_a5a5);
        send_item(MODE_LOAD_A, -32'sd5);
        send_item(MODE_LOAD_A, 32'sd5);
        send_item(MODE_MERGE, 32'hffff_ffff);
        send_item(MODE_LOAD_B, 32'sd3);
        send_item(MODE_UNUSED, 32'h0);
        send_item(MODE_LOAD_B, 32'sd4);
        send_item(MODE_MERGE, 32'h8000_0000);
    endtask

    task automatic test_full_lists();
        merge_round(LIST_DEPTH, LIST_DEPTH, 0, 1'b1);
        send_item(MODE_LOAD_A, 32'sd9);
        for (int i = 0; i < LIST_DEPTH; i++) send_item(MODE_LOAD_A, i);
        send_item(MODE_LOAD_A, 32'sd100);
        send_item(MODE_LOAD_B, 32'sd7);
        send_item(MODE_MERGE, 32'sd0);
    endtask

    task automatic test_random_rounds();
        int half;
        half = (sent_items + RANDOM_TARGET) / 2;
        while (sent_items < RANDOM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       merge_round(rand_len(), rand_len(), 0, 1'b0);
                1, 2:    merge_round(rand_len(), rand_len(), 0, 1'b1);
                default: merge_round(rand_len(), rand_len(), $urandom_range(1, 4), 1'b1);
            endcase
            if (sent_items >= half && half != 0) begin
                drain_pending();
                half = 0;
            end
        end
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        repeat (6) merge_round($urandom_range(0, 5), $urandom_range(0, 5), 3, 1'b1);
        merge_round(0, 0, 0, 1'b1);
    endtask

    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    t_out_item want;

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending.size() == 0) begin
                $error("unexpected result: value_res %0d position %0d status %0d",
                       o_out_item.value_res, o_out_item.position, o_out_item.status);
                mismatches++;
            end else begin
                want = pending.pop_front();
                if (o_out_item.value_res !== want.value_res) begin
                    $error("value_res: expected %0d, got %0d", want.value_res,
                           o_out_item.value_res);
                    mismatches++;
                end
                if (o_out_item.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           o_out_item.position);
                    mismatches++;
                end
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    mismatches++;
                end
                if (o_out_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_item.last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_merge();
        test_extremes();
        test_full_lists();
        test_random_rounds();
        test_full_rate();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
